// ===== rtl/core/ash_pkg.sv =====
// Package for the affine shear block with nearest-neighbour sampling.
// Holds field widths, register indices, command codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ash_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int DET_SHIFT  = 24;
  localparam int DIM_W      = 9;
  localparam int SCALE_W    = 16;
  localparam int SHIFT_W    = 24;
  localparam int SHEAR_W    = 10;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_SHIFT_X,
    REG_SHIFT_Y,
    REG_SHEAR_X,
    REG_SHEAR_Y
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_OW_MUL,
    ST_OH_MUL,
    ST_DIM_SET,
    ST_B_DIV,
    ST_B_WAIT,
    ST_C_DIV,
    ST_C_WAIT,
    ST_NX_MUL,
    ST_NX_MUL2,
    ST_NX_SUB,
    ST_X_DIV,
    ST_X_WAIT,
    ST_NY_MUL,
    ST_NY_MUL2,
    ST_NY_SUB,
    ST_Y_DIV,
    ST_Y_WAIT,
    ST_CHECK,
    ST_ADDR,
    ST_MEM_RD,
    ST_OUT
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ash_if.sv =====
// Channel interfaces of the affine shear block: pixel input, pixel output and
// configuration write. Depends on ash_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ash_pix_in_if import ash_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            command;
  logic [CH_W-1:0] pixel_blue;
  logic [CH_W-1:0] pixel_green;
  logic [CH_W-1:0] pixel_red;
  modport source(output valid, command, pixel_blue, pixel_green, pixel_red, input ready);
  modport sink(input valid, command, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

interface ash_pix_out_if import ash_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_red;
  logic            row_end;
  logic            frame_end;
  modport source(output valid, out_blue, out_green, out_red, row_end, frame_end, input ready);
  modport sink(input valid, out_blue, out_green, out_red, row_end, frame_end, output ready);
endinterface

interface ash_cfg_if import ash_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;
  modport source(output valid, reg_index, reg_data, input ready);
  modport sink(input valid, reg_index, reg_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ash_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module ash_mul #(
  parameter int A_W = 22,
  parameter int B_W = 17
) (
  input  wire                        clk,
  input  wire logic signed [A_W-1:0] a,
  input  wire logic signed [B_W-1:0] b,
  output logic signed [A_W+B_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ash_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero.
// Signed dividend, positive unsigned divisor. Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module ash_div #(
  parameter int N_W = 64,
  parameter int D_W = 32
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire logic signed [N_W-1:0] dividend,
  input  wire logic [D_W-1:0]        divisor,
  output logic                       busy,
  output logic                       done,
  output logic signed [N_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W-1:0]   rem;
  logic [N_W-1:0]   quo;
  logic [D_W-1:0]   dvs;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [N_W-1:0]   mag;
  logic [D_W:0]     shifted;
  logic             ge;

  assign mag      = dividend[N_W-1] ? N_W'(-dividend) : N_W'(dividend);
  assign shifted  = {rem, quo[N_W-1]};
  assign ge       = shifted >= {1'b0, dvs};
  assign quotient = neg ? $signed(-quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= mag;
      dvs <= divisor;
      neg <= dividend[N_W-1];
      cnt <= CNT_W'(N_W);
    end else if (busy) begin
      rem <= ge ? D_W'(shifted - {1'b0, dvs}) : shifted[D_W-1:0];
      quo <= {quo[N_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ash_store.sv =====
// Source frame store with its raster load position and a registered read port.
// Depends on ash_pkg for the pixel and dimension widths.
`timescale 1ns / 1ps
`default_nettype none

module ash_store import ash_pkg::*; #(
  parameter int ADDR_W = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     wr_en,
  input  wire logic [PIX_W-1:0]   wr_data,
  input  wire logic [DIM_W-1:0]   width,
  input  wire logic [DIM_W-1:0]   height,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic [PIX_W-1:0]        rd_data
);

  localparam int CMP_W = (ADDR_W + 1 > 2 * DIM_W) ? ADDR_W + 1 : 2 * DIM_W;

  logic [PIX_W-1:0]   mem [2**ADDR_W];
  logic [ADDR_W-1:0]  pos;
  logic [CMP_W-1:0]   area;
  logic [ADDR_W-1:0]  wr_pos;
  logic [CMP_W-1:0]   pos_inc;

  assign area    = CMP_W'(width) * CMP_W'(height);
  assign wr_pos  = (CMP_W'(pos) >= area) ? '0 : pos;
  assign pos_inc = CMP_W'(wr_pos) + CMP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (wr_en) begin
      pos <= (pos_inc >= area) ? '0 : pos_inc[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/affine_shear_nearest_neighbour.sv =====
// Top level of the affine shear block: configuration registers, sequencer and datapath.
// Depends on ash_pkg, ash_if, ash_mul, ash_div and ash_store.
//
//   channel    dir   beat contents
//   pix_in     in    command, pixel_blue, pixel_green, pixel_red
//   pix_out    out   out_blue, out_green, out_red, row_end, frame_end
//   cfg        in    reg_index, reg_data (always ready)
//
// A load beat is written straight into the frame store. A request beat runs four divisions
// on the shared divider, which yields one quotient bit per cycle, between the multiply,
// subtract, check, address, read and output steps of the sequencer; no new beat is taken
// until the finished pixel is loaded into the output register.
// Reset is synchronous; the frame store is not cleared. A finished pixel waits in the
// output register while loads go on; a following request stalls at its last step.
`timescale 1ns / 1ps
`default_nettype none

module affine_shear_nearest_neighbour import ash_pkg::*; #(
  parameter int MAX_SRC_DIM = 256,
  parameter int MAX_OUT_DIM = 512
) (
  input  wire             clk,
  input  wire             rst,
  ash_pix_in_if.sink      pix_in,
  ash_pix_out_if.source   pix_out,
  ash_cfg_if.sink         cfg
);

  localparam int OUT_W   = $clog2(MAX_OUT_DIM + 1);
  localparam int AX_W    = $clog2(MAX_SRC_DIM);
  localparam int ADDR_W  = 2 * AX_W;
  localparam int MA_W    = SHEAR_W + FRAC_BITS;
  localparam int MB_BASE = (SCALE_W > OUT_W) ? SCALE_W : OUT_W;
  localparam int MB_W    = ((MB_BASE > DIM_W) ? MB_BASE : DIM_W) + 1;
  localparam int MP_W    = MA_W + MB_W;
  localparam int NX_W    = MP_W + 1;
  localparam int DVD_W   = NX_W + DET_SHIFT;
  localparam int DVS_W   = 2 * SCALE_W;

  localparam logic signed [MP_W:0]  DIM_ONE_Q = (MP_W + 1)'(1) <<< FRAC_BITS;
  localparam logic signed [MP_W:0]  DIM_MAX   = (MP_W + 1)'(MAX_OUT_DIM);
  localparam logic signed [DVD_W:0] NEG_ONE_Q = -((DVD_W + 1)'(1) <<< FRAC_BITS);

  logic [DIM_W-1:0]          src_width;
  logic [DIM_W-1:0]          src_height;
  logic [SCALE_W-1:0]        scale_x;
  logic [SCALE_W-1:0]        scale_y;
  logic signed [SHIFT_W-1:0] shift_x;
  logic signed [SHIFT_W-1:0] shift_y;
  logic signed [SHEAR_W-1:0] shear_x;
  logic signed [SHEAR_W-1:0] shear_y;

  seq_state_t state;
  seq_state_t state_next;

  logic [OUT_W-1:0]          col;
  logic [OUT_W-1:0]          row;
  logic [OUT_W-1:0]          ow;
  logic [OUT_W-1:0]          oh;
  logic [DVS_W-1:0]          det;
  logic signed [MA_W-1:0]    bq;
  logic signed [MA_W-1:0]    cq;
  logic signed [NX_W-1:0]    acc;
  logic signed [DVD_W:0]     diff_x;
  logic signed [DVD_W:0]     diff_y;
  logic                      hit;
  logic [AX_W-1:0]           px_idx;
  logic [ADDR_W-1:0]         addr;

  logic [DIM_W-1:0]          w_eff;
  logic [DIM_W-1:0]          h_eff;
  logic [SCALE_W-1:0]        sx_eff;
  logic [SCALE_W-1:0]        sy_eff;

  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [MP_W-1:0]    prod;

  logic                      div_start;
  logic signed [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]          div_dvs;
  logic                      div_busy;
  logic                      div_done;
  logic signed [DVD_W-1:0]   div_quo;

  logic                      in_fire;
  logic                      out_load;
  logic [PIX_W-1:0]          rd_data;
  logic [OUT_W-1:0]          oh_new;
  logic [OUT_W:0]            row_inc;
  logic [OUT_W-1:0]          row_norm;
  logic                      in_x;
  logic                      in_y;
  logic [AX_W-1:0]           px_c;
  logic [AX_W-1:0]           py_c;
  logic                      rend;
  logic                      fend;

  function automatic logic [OUT_W-1:0] out_dim(input logic signed [MP_W:0] s);
    logic signed [MP_W:0] n;
    begin
      n = s >>> FRAC_BITS;
      if (s < DIM_ONE_Q) begin
        out_dim = OUT_W'(1);
      end else if (n > DIM_MAX) begin
        out_dim = OUT_W'(MAX_OUT_DIM);
      end else begin
        out_dim = n[OUT_W-1:0];
      end
    end
  endfunction

  assign w_eff  = (src_width == '0) ? DIM_W'(1) :
                  (int'(src_width) > MAX_SRC_DIM) ? DIM_W'(MAX_SRC_DIM) : src_width;
  assign h_eff  = (src_height == '0) ? DIM_W'(1) :
                  (int'(src_height) > MAX_SRC_DIM) ? DIM_W'(MAX_SRC_DIM) : src_height;
  assign sx_eff = (scale_x == '0) ? SCALE_W'(1) : scale_x;
  assign sy_eff = (scale_y == '0) ? SCALE_W'(1) : scale_y;

  assign cfg.ready    = 1'b1;
  assign pix_in.ready = (state == ST_IDLE);
  assign in_fire      = pix_in.valid && pix_in.ready;
  assign out_load     = (state == ST_OUT) && (!pix_out.valid || pix_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_W'(128);
      src_height <= DIM_W'(128);
      scale_x    <= SCALE_W'(4096);
      scale_y    <= SCALE_W'(4096);
      shift_x    <= '0;
      shift_y    <= '0;
      shear_x    <= '0;
      shear_y    <= '0;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.reg_index))
        REG_SRC_WIDTH:  src_width  <= cfg.reg_data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg.reg_data[DIM_W-1:0];
        REG_SCALE_X:    scale_x    <= cfg.reg_data[SCALE_W-1:0];
        REG_SCALE_Y:    scale_y    <= cfg.reg_data[SCALE_W-1:0];
        REG_SHIFT_X:    shift_x    <= cfg.reg_data[SHIFT_W-1:0];
        REG_SHIFT_Y:    shift_y    <= cfg.reg_data[SHIFT_W-1:0];
        REG_SHEAR_X:    shear_x    <= cfg.reg_data[SHEAR_W-1:0];
        REG_SHEAR_Y:    shear_y    <= cfg.reg_data[SHEAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    case (state)
      ST_IDLE: begin
        if (in_fire && (pix_in.command == CMD_REQUEST)) begin
          state_next = ST_OW_MUL;
        end
      end
      ST_OW_MUL: begin
        mul_a      = MA_W'(sx_eff);
        mul_b      = MB_W'(w_eff);
        state_next = ST_OH_MUL;
      end
      ST_OH_MUL: begin
        mul_a      = MA_W'(sy_eff);
        mul_b      = MB_W'(h_eff);
        state_next = ST_DIM_SET;
      end
      ST_DIM_SET: begin
        mul_a      = MA_W'(sx_eff);
        mul_b      = MB_W'(sy_eff);
        state_next = ST_B_DIV;
      end
      ST_B_DIV: begin
        div_start  = 1'b1;
        div_dvd    = DVD_W'(shear_x) <<< FRAC_BITS;
        div_dvs    = DVS_W'(oh);
        state_next = ST_B_WAIT;
      end
      ST_B_WAIT: begin
        if (div_done) begin
          state_next = ST_C_DIV;
        end
      end
      ST_C_DIV: begin
        div_start  = 1'b1;
        div_dvd    = DVD_W'(shear_y) <<< FRAC_BITS;
        div_dvs    = DVS_W'(ow);
        state_next = ST_C_WAIT;
      end
      ST_C_WAIT: begin
        if (div_done) begin
          state_next = ST_NX_MUL;
        end
      end
      ST_NX_MUL: begin
        mul_a      = MA_W'(sy_eff);
        mul_b      = MB_W'(col);
        state_next = ST_NX_MUL2;
      end
      ST_NX_MUL2: begin
        mul_a      = bq;
        mul_b      = MB_W'(row);
        state_next = ST_NX_SUB;
      end
      ST_NX_SUB: begin
        state_next = ST_X_DIV;
      end
      ST_X_DIV: begin
        div_start  = 1'b1;
        div_dvd    = {acc, {DET_SHIFT{1'b0}}};
        div_dvs    = det;
        state_next = ST_X_WAIT;
      end
      ST_X_WAIT: begin
        if (div_done) begin
          state_next = ST_NY_MUL;
        end
      end
      ST_NY_MUL: begin
        mul_a      = MA_W'(sx_eff);
        mul_b      = MB_W'(row);
        state_next = ST_NY_MUL2;
      end
      ST_NY_MUL2: begin
        mul_a      = cq;
        mul_b      = MB_W'(col);
        state_next = ST_NY_SUB;
      end
      ST_NY_SUB: begin
        state_next = ST_Y_DIV;
      end
      ST_Y_DIV: begin
        div_start  = 1'b1;
        div_dvd    = {acc, {DET_SHIFT{1'b0}}};
        div_dvs    = det;
        state_next = ST_Y_WAIT;
      end
      ST_Y_WAIT: begin
        if (div_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        mul_a      = MA_W'(py_c);
        mul_b      = MB_W'(w_eff);
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        state_next = ST_MEM_RD;
      end
      ST_MEM_RD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign oh_new   = out_dim((MP_W + 1)'(prod) + ((MP_W + 1)'(shear_y) <<< FRAC_BITS));
  assign row_inc  = (col >= ow) ? (OUT_W + 1)'(row) + (OUT_W + 1)'(1) : (OUT_W + 1)'(row);
  assign row_norm = (row_inc >= (OUT_W + 1)'(oh_new)) ? '0 : row_inc[OUT_W-1:0];

  assign in_x = diff_x[DVD_W] ? (diff_x > NEG_ONE_Q) :
                ((diff_x >>> FRAC_BITS) < $signed((DVD_W + 1)'(w_eff)));
  assign in_y = diff_y[DVD_W] ? (diff_y > NEG_ONE_Q) :
                ((diff_y >>> FRAC_BITS) < $signed((DVD_W + 1)'(h_eff)));
  assign px_c = diff_x[DVD_W] ? '0 : diff_x[FRAC_BITS +: AX_W];
  assign py_c = diff_y[DVD_W] ? '0 : diff_y[FRAC_BITS +: AX_W];

  assign rend = (col == ow - OUT_W'(1));
  assign fend = rend && (row == oh - OUT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (state == ST_DIM_SET) begin
      if (col >= ow) begin
        col <= '0;
      end
      row <= row_norm;
    end else if (out_load) begin
      if (fend) begin
        col <= '0;
        row <= '0;
      end else if (rend) begin
        col <= '0;
        row <= row + OUT_W'(1);
      end else begin
        col <= col + OUT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_OH_MUL:  ow <= out_dim((MP_W + 1)'(prod) + ((MP_W + 1)'(shear_x) <<< FRAC_BITS));
      ST_DIM_SET: oh <= oh_new;
      ST_B_DIV:   det <= prod[DVS_W-1:0];
      ST_B_WAIT:  bq <= MA_W'(div_quo);
      ST_C_WAIT:  cq <= MA_W'(div_quo);
      ST_NX_MUL2: acc <= NX_W'(prod);
      ST_NX_SUB:  acc <= acc - NX_W'(prod);
      ST_X_WAIT:  diff_x <= (DVD_W + 1)'(div_quo) - (DVD_W + 1)'(shift_x);
      ST_NY_MUL2: acc <= NX_W'(prod);
      ST_NY_SUB:  acc <= acc - NX_W'(prod);
      ST_Y_WAIT:  diff_y <= (DVD_W + 1)'(div_quo) - (DVD_W + 1)'(shift_y);
      ST_CHECK: begin
        hit    <= in_x && in_y;
        px_idx <= px_c;
      end
      ST_ADDR:    addr <= prod[ADDR_W-1:0] + ADDR_W'(px_idx);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (out_load) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pix_out.out_blue  <= hit ? rd_data[CH_W-1:0] : '0;
      pix_out.out_green <= hit ? rd_data[CH_W +: CH_W] : '0;
      pix_out.out_red   <= hit ? rd_data[2*CH_W +: CH_W] : '0;
      pix_out.row_end   <= rend;
      pix_out.frame_end <= fend;
    end
  end

  ash_mul #(
    .A_W(MA_W),
    .B_W(MB_W)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  ash_div #(
    .N_W(DVD_W),
    .D_W(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_quo)
  );

  ash_store #(
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (in_fire && (pix_in.command == CMD_LOAD)),
    .wr_data({pix_in.pixel_red, pix_in.pixel_green, pix_in.pixel_blue}),
    .width  (w_eff),
    .height (h_eff),
    .rd_addr(addr),
    .rd_data(rd_data)
  );

`ifndef NO_ASSERTIONS
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_busy)
    else $error("Divider busy while the sequencer is idle.");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_B_WAIT || state == ST_C_WAIT ||
                  state == ST_X_WAIT || state == ST_Y_WAIT))
    else $error("Divider finished outside a wait step.");

  a_norm: assert property (@(posedge clk) disable iff (rst)
    (state == ST_B_DIV) |-> (col < ow) && (row < oh))
    else $error("Output position not inside the output frame after normalisation.");
`endif

endmodule

`default_nettype wire
